FILE: sv/fptg_pkg.sv
// ----------------------------------------------------------------------------
// fptg_pkg
// Shared types and constants of the frame-paced tick governor.
// ----------------------------------------------------------------------------
package fptg_pkg;

    localparam int unsigned FrameRateW  = 8;
    localparam int unsigned TickRateW   = 6;
    localparam int unsigned GuardW      = 16;
    localparam int unsigned FailW       = 4;
    localparam int unsigned BudgetW     = 8;
    localparam int unsigned SumW        = 9;
    localparam int unsigned CfgIndexW   = 2;
    localparam int unsigned CfgDataW    = 16;
    localparam int unsigned DivCountW   = 4;

    localparam logic [FrameRateW-1:0] FrameRateReset  = 8'd50;
    localparam logic [TickRateW-1:0]  TickRateReset   = 6'd8;
    localparam logic [GuardW-1:0]     GuardLimitReset = 16'd4000;
    localparam logic [FailW-1:0]      FailLimitReset  = 4'd3;

    localparam logic [FailW-1:0]      FailMax         = 4'd15;
    localparam logic [BudgetW-1:0]    BudgetMax       = 8'd255;

    typedef enum logic [1:0] {
        OP_BEGIN_TICK = 2'd0,
        OP_WORK_POLL  = 2'd1,
        OP_WAIT_POLL  = 2'd2,
        OP_NONE       = 2'd3
    } t_opcode;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_FRAME_RATE  = 2'd0,
        CFG_TICK_RATE   = 2'd1,
        CFG_GUARD_LIMIT = 2'd2,
        CFG_FAIL_LIMIT  = 2'd3
    } t_cfg_index;

endpackage

FILE: sv/frame_paced_tick_governor.sv
// A begin-tick item has an accept step, nine restoring-division steps
// through a single 7-bit subtract/compare unit to split the frame sum
// into budget and remainder, and a step that loads the result register.
// With a zero tick_rate the division is skipped; pulse and wait polls
// also go straight to the result step. A result that waits on i_ready
// holds the sequencer in its last step. Input ready is high only while
// the sequencer is idle; configuration writes are always taken.
// ----------------------------------------------------------------------------
// frame_paced_tick_governor
// Paces ticks against a frame pulse with a fractional budget and a watchdog.
// ----------------------------------------------------------------------------
module frame_paced_tick_governor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_opcode,
    input  logic                           i_pulse_level,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_wait_over,
    output logic                           o_timed_out,
    output logic [fptg_pkg::BudgetW-1:0]   o_budget_left,
    output logic                           o_pacing_off,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fptg_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [fptg_pkg::CfgDataW-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [fptg_pkg::FrameRateW-1:0] r_frame_rate;
    logic [fptg_pkg::TickRateW-1:0]  r_tick_rate;
    logic [fptg_pkg::GuardW-1:0]     r_guard_limit;
    logic [fptg_pkg::FailW-1:0]      r_fail_limit;

    logic [fptg_pkg::BudgetW-1:0]    r_acc, n_acc;
    logic [fptg_pkg::BudgetW-1:0]    r_budget, n_budget;
    logic                            r_last, n_last;
    logic [fptg_pkg::GuardW-1:0]     r_guard, n_guard;
    logic [fptg_pkg::FailW-1:0]      r_fail_count, n_fail_count;
    logic                            r_disabled, n_disabled;
    logic                            r_wait_fin, n_wait_fin;
    logic                            r_tout, n_tout;

    logic [fptg_pkg::SumW-1:0]       r_div_sh, n_div_sh;
    logic [fptg_pkg::TickRateW-1:0]  r_rem, n_rem;
    logic [fptg_pkg::SumW-1:0]       r_quo, n_quo;
    logic [fptg_pkg::DivCountW-1:0]  r_cnt, n_cnt;

    logic                            r_o_valid, n_o_valid;
    logic                            r_o_wait_over, n_o_wait_over;
    logic                            r_o_timed_out, n_o_timed_out;
    logic [fptg_pkg::BudgetW-1:0]    r_o_budget, n_o_budget;
    logic                            r_o_pacing_off, n_o_pacing_off;

    logic [fptg_pkg::SumW-1:0]       w_sum;
    logic [fptg_pkg::TickRateW:0]    w_trial;
    logic                            w_ge;
    logic [fptg_pkg::TickRateW:0]    w_diff;
    logic [fptg_pkg::GuardW-1:0]     w_guard_dec;
    logic [fptg_pkg::FailW-1:0]      w_fail_inc;
    logic                            w_accept;
    fptg_pkg::t_opcode               w_op;

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_o_valid;
    assign o_wait_over   = r_o_wait_over;
    assign o_timed_out   = r_o_timed_out;
    assign o_budget_left = r_o_budget;
    assign o_pacing_off  = r_o_pacing_off;

    assign w_accept    = i_valid && o_ready;
    assign w_op        = fptg_pkg::t_opcode'(i_opcode);
    assign w_sum       = {1'b0, r_acc} + {1'b0, r_frame_rate};
    assign w_trial     = {r_rem, r_div_sh[fptg_pkg::SumW-1]};
    assign w_ge        = (w_trial >= {1'b0, r_tick_rate});
    assign w_diff      = w_trial - {1'b0, r_tick_rate};
    assign w_guard_dec = (r_guard != '0) ? r_guard - 1'b1 : '0;
    assign w_fail_inc  = (r_fail_count < fptg_pkg::FailMax) ? r_fail_count + 1'b1
                                                           : r_fail_count;

    always_comb begin
        n_state        = r_state;
        n_acc          = r_acc;
        n_budget       = r_budget;
        n_last         = r_last;
        n_guard        = r_guard;
        n_fail_count   = r_fail_count;
        n_disabled     = r_disabled;
        n_wait_fin     = r_wait_fin;
        n_tout         = r_tout;
        n_div_sh       = r_div_sh;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_cnt          = r_cnt;
        n_o_valid      = r_o_valid && !i_ready;
        n_o_wait_over  = r_o_wait_over;
        n_o_timed_out  = r_o_timed_out;
        n_o_budget     = r_o_budget;
        n_o_pacing_off = r_o_pacing_off;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_tout  = 1'b0;
                    n_state = S_DONE;
                    case (w_op)
                        fptg_pkg::OP_BEGIN_TICK: begin
                            n_guard    = r_guard_limit;
                            n_wait_fin = 1'b0;
                            if (r_tick_rate == '0) begin
                                n_budget = fptg_pkg::BudgetMax;
                                n_acc    = '0;
                            end else begin
                                n_div_sh = w_sum;
                                n_rem    = '0;
                                n_quo    = '0;
                                n_cnt    = fptg_pkg::DivCountW'(fptg_pkg::SumW);
                                n_state  = S_DIV;
                            end
                        end
                        fptg_pkg::OP_WORK_POLL: begin
                            if (i_pulse_level != r_last) begin
                                n_last = i_pulse_level;
                                if (i_pulse_level && r_budget != '0) begin
                                    n_budget = r_budget - 1'b1;
                                end
                            end
                        end
                        fptg_pkg::OP_WAIT_POLL: begin
                            if (r_disabled || r_wait_fin) begin
                                n_wait_fin = 1'b1;
                            end else if (r_budget == '0) begin
                                n_fail_count = '0;
                                n_wait_fin   = 1'b1;
                            end else begin
                                n_guard = w_guard_dec;
                                if (w_guard_dec == '0) begin
                                    n_tout       = 1'b1;
                                    n_fail_count = w_fail_inc;
                                    if (w_fail_inc >= r_fail_limit) begin
                                        n_disabled = 1'b1;
                                    end
                                    n_wait_fin = 1'b1;
                                end else if (i_pulse_level != r_last) begin
                                    n_last = i_pulse_level;
                                    if (i_pulse_level) begin
                                        n_budget = r_budget - 1'b1;
                                        if (r_budget == 8'd1) begin
                                            n_fail_count = '0;
                                            n_wait_fin   = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_div_sh = {r_div_sh[fptg_pkg::SumW-2:0], 1'b0};
                n_quo    = {r_quo[fptg_pkg::SumW-2:0], w_ge};
                n_rem    = w_ge ? w_diff[fptg_pkg::TickRateW-1:0]
                                : w_trial[fptg_pkg::TickRateW-1:0];
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == 4'd1) begin
                    n_acc    = {{(fptg_pkg::BudgetW-fptg_pkg::TickRateW){1'b0}}, n_rem};
                    n_budget = n_quo[fptg_pkg::SumW-1] ? fptg_pkg::BudgetMax
                                                        : n_quo[fptg_pkg::BudgetW-1:0];
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid      = 1'b1;
                    n_o_wait_over  = r_wait_fin;
                    n_o_timed_out  = r_tout;
                    n_o_budget     = r_budget;
                    n_o_pacing_off = r_disabled;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_rate  <= fptg_pkg::FrameRateReset;
            r_tick_rate   <= fptg_pkg::TickRateReset;
            r_guard_limit <= fptg_pkg::GuardLimitReset;
            r_fail_limit  <= fptg_pkg::FailLimitReset;
            r_acc         <= '0;
            r_budget      <= '0;
            r_last        <= 1'b0;
            r_guard       <= '0;
            r_fail_count  <= '0;
            r_disabled    <= 1'b0;
            r_wait_fin    <= 1'b0;
            r_tout        <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_acc        <= n_acc;
            r_budget     <= n_budget;
            r_last       <= n_last;
            r_guard      <= n_guard;
            r_fail_count <= n_fail_count;
            r_disabled   <= n_disabled;
            r_wait_fin   <= n_wait_fin;
            r_tout       <= n_tout;
            r_o_valid    <= n_o_valid;
            if (i_cfg_valid) begin
                case (fptg_pkg::t_cfg_index'(i_cfg_index))
                    fptg_pkg::CFG_FRAME_RATE:
                        r_frame_rate <= i_cfg_data[fptg_pkg::FrameRateW-1:0];
                    fptg_pkg::CFG_TICK_RATE:
                        r_tick_rate <= i_cfg_data[fptg_pkg::TickRateW-1:0];
                    fptg_pkg::CFG_GUARD_LIMIT:
                        r_guard_limit <= i_cfg_data[fptg_pkg::GuardW-1:0];
                    fptg_pkg::CFG_FAIL_LIMIT:
                        r_fail_limit <= i_cfg_data[fptg_pkg::FailW-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_div_sh       <= n_div_sh;
        r_rem          <= n_rem;
        r_quo          <= n_quo;
        r_cnt          <= n_cnt;
        r_o_wait_over  <= n_o_wait_over;
        r_o_timed_out  <= n_o_timed_out;
        r_o_budget     <= n_o_budget;
        r_o_pacing_off <= n_o_pacing_off;
    end

    a_disabled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disabled |=> r_disabled)
        else $error("pacing re-enabled after disable");

    a_disabled_has_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disabled |-> (r_fail_count != '0))
        else $error("pacing disabled with no recorded timeout");

    a_timeout_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_timed_out) |-> o_wait_over)
        else $error("timeout reported without end of wait");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < {1'b0, r_tick_rate}))
        else $error("division remainder out of range");

endmodule
